// ===== rtl/tlvp_pkg.sv =====
// Package for the TLV frame parser: parser state, result record and constants.
// Used by the configuration interface, the parse step and the top level.
package tlvp_pkg;

	localparam int unsigned CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_FIRST  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_SECOND = CFG_INDEX_W'(1);

	localparam logic [7:0] PREAMBLE_FIRST_RST  = 8'h55;
	localparam logic [7:0] PREAMBLE_SECOND_RST = 8'hAA;

	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_TAG    = 5'b00010,
		PH_LENGTH = 5'b00100,
		PH_VALUE  = 5'b01000,
		PH_CHECK  = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic       pre_hit;
		logic [7:0] tag;
		logic [7:0] length;
		logic [7:0] value_count;
		logic [7:0] running_sum;
	} state_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       frame_done;
		logic       frame_ok;
		logic [7:0] frame_tag;
		logic [7:0] frame_length;
	} result_t;

endpackage

// ===== rtl/tlvp_if.sv =====
// Valid/ready channel interfaces of the TLV frame parser.
// Depends on tlvp_pkg for the configuration index width.
interface tlvp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
	modport mon    (input valid, input rx_byte, input ready);
endinterface

interface tlvp_result_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic       frame_done;
	logic       frame_ok;
	logic [7:0] frame_tag;
	logic [7:0] frame_length;

	modport source (output valid, output payload_valid, output payload_byte,
		output payload_index, output frame_done, output frame_ok,
		output frame_tag, output frame_length, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input payload_index, input frame_done, input frame_ok,
		input frame_tag, input frame_length, output ready);
	modport mon (input valid, input payload_valid, input payload_byte,
		input payload_index, input frame_done, input frame_ok,
		input frame_tag, input frame_length, input ready);
endinterface

interface tlvp_cfg_if
	import tlvp_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] reg_index;
	logic [7:0]             wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
	modport mon    (input valid, input reg_index, input wr_data, input ready);
endinterface

// ===== rtl/tlvp_step.sv =====
// Combinational parse step: next parser state and result for one byte.
// Depends on tlvp_pkg.
module tlvp_step
	import tlvp_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] rx_byte,
	input  logic [7:0] preamble_first,
	input  logic [7:0] preamble_second,
	output state_t     nxt,
	output result_t    res
);

	logic [7:0] count_inc;

	assign count_inc = cur.value_count + 8'd1;

	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.phase)
			PH_TAG: begin
				nxt.tag   = rx_byte;
				nxt.phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				nxt.length      = rx_byte;
				nxt.value_count = 8'd0;
				nxt.running_sum = 8'd0;
				nxt.phase       = (rx_byte == 8'd0) ? PH_CHECK : PH_VALUE;
			end
			PH_VALUE: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = cur.value_count;
				nxt.running_sum   = cur.running_sum + rx_byte;
				nxt.value_count   = count_inc;
				if (count_inc == cur.length) begin
					nxt.phase = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res.frame_done = 1'b1;
				res.frame_ok   = (rx_byte == cur.running_sum);
				nxt.phase      = PH_HUNT;
				nxt.pre_hit    = 1'b0;
			end
			default: begin
				nxt.phase = PH_HUNT;
				if (cur.phase == PH_HUNT && cur.pre_hit && rx_byte == preamble_second) begin
					nxt.pre_hit = 1'b0;
					nxt.phase   = PH_TAG;
				end else begin
					nxt.pre_hit = (rx_byte == preamble_first);
				end
			end
		endcase
		res.frame_tag    = nxt.tag;
		res.frame_length = nxt.length;
	end

endmodule

// ===== rtl/tlv_frame_parser_top.sv =====
// Top level of the TLV frame parser: state and result registers, config port.
// Depends on tlvp_pkg, the channel interfaces in tlvp_if and tlvp_step.
//
//   channel     role   payload
//   byte_ch     sink   rx_byte, one received byte per request
//   result_ch   source one result per byte: payload, frame status, tag, length
//   cfg_ch      sink   reg_index, wr_data; 0 = first, 1 = second preamble byte
//
// Every byte is parsed combinationally and its result is registered; a byte can be
// taken in every cycle while the result channel is not stalled, so the sustained rate is one byte per clock.
// The result request is raised in the cycle after the byte is taken.
// byte_ch.ready is high while the result register is empty or being taken.
// Reset clears the parser to preamble hunting and loads the default preambles.
// Configuration writes are always taken and act on the next byte.
module tlv_frame_parser_top
	import tlvp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	tlvp_byte_if.sink            byte_ch,
	tlvp_result_if.source        result_ch,
	tlvp_cfg_if.sink             cfg_ch
);

	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       res_valid_q;
	logic       byte_take;
	logic [7:0] preamble_first_q;
	logic [7:0] preamble_second_q;

	assign byte_ch.ready = !res_valid_q || result_ch.ready;
	assign byte_take     = byte_ch.valid && byte_ch.ready;
	assign cfg_ch.ready  = 1'b1;

	tlvp_step u_step (
		.cur             (state_q),
		.rx_byte         (byte_ch.rx_byte),
		.preamble_first  (preamble_first_q),
		.preamble_second (preamble_second_q),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_first_q  <= PREAMBLE_FIRST_RST;
			preamble_second_q <= PREAMBLE_SECOND_RST;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.reg_index == REG_PREAMBLE_FIRST) begin
				preamble_first_q <= cfg_ch.wr_data;
			end
			if (cfg_ch.reg_index == REG_PREAMBLE_SECOND) begin
				preamble_second_q <= cfg_ch.wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_HUNT;
			state_q.pre_hit     <= 1'b0;
			state_q.tag         <= 8'd0;
			state_q.length      <= 8'd0;
			state_q.value_count <= 8'd0;
			state_q.running_sum <= 8'd0;
			res_valid_q         <= 1'b0;
		end else begin
			if (byte_take) begin
				state_q <= state_nxt;
			end
			if (byte_ch.ready) begin
				res_valid_q <= byte_ch.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			res_q <= res_nxt;
		end
	end

	assign result_ch.valid         = res_valid_q;
	assign result_ch.payload_valid = res_q.payload_valid;
	assign result_ch.payload_byte  = res_q.payload_byte;
	assign result_ch.payload_index = res_q.payload_index;
	assign result_ch.frame_done    = res_q.frame_done;
	assign result_ch.frame_ok      = res_q.frame_ok;
	assign result_ch.frame_tag     = res_q.frame_tag;
	assign result_ch.frame_length  = res_q.frame_length;

endmodule

// ===== rtl/tlvp_checker.sv =====
// Port-level assertions for the TLV frame parser, bound to the top level.
// Depends on the handshake and result ports of tlv_frame_parser_top.
module tlvp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       payload_valid,
	input logic [7:0] payload_byte,
	input logic [7:0] payload_index,
	input logic       frame_done,
	input logic       frame_ok,
	input logic [7:0] frame_tag
);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> byte_ready)
		else $error("byte channel stalled with an empty result register");

	a_done_excl_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(payload_valid && frame_done))
		else $error("result flags a value byte and a checksum byte at once");

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_ok) |-> frame_done)
		else $error("frame_ok raised outside a checksum result");

	a_idle_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !payload_valid) |->
			(payload_byte == 8'd0 && payload_index == 8'd0))
		else $error("payload fields not cleared outside a value byte");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
			(res_valid && $stable(frame_tag) && $stable(payload_byte)))
		else $error("stalled result request changed");

endmodule

bind tlv_frame_parser_top tlvp_checker u_tlvp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.byte_ready    (byte_ch.ready),
	.res_valid     (result_ch.valid),
	.res_ready     (result_ch.ready),
	.payload_valid (result_ch.payload_valid),
	.payload_byte  (result_ch.payload_byte),
	.payload_index (result_ch.payload_index),
	.frame_done    (result_ch.frame_done),
	.frame_ok      (result_ch.frame_ok),
	.frame_tag     (result_ch.frame_tag)
);
